@@ design/sofab_pkg.sv @@
// Shared types and constants for the second-order Adams-Bashforth filter.
// Used by sofab_mul and second_order_filter_ab2; no dependencies.
`timescale 1ns / 1ps

package sofab_pkg;

    // configuration register indexes
    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_NUM_S2 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_NUM_S1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NUM_S0 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DEN_S1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DEN_S0 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STEP   = 3'd5;

    // reset codes of the registers
    localparam logic [31:0] RESET_UNITY = 32'd65536;
    localparam logic [30:0] RESET_STEP  = 31'd655;
    localparam int          STEP_W      = 31;

    // sequencer of one sample
    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT,
        S_DONE
    } t_seq_state;

    // the seven products of one sample, in issue order
    typedef enum logic [2:0] {
        OP_DAMP,
        OP_STIFF,
        OP_VEL,
        OP_POS,
        OP_OUT2,
        OP_OUT1,
        OP_OUT0
    } t_op;

    // digit-serial multiplier
    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_ROUND
    } t_mul_state;

    typedef struct packed {
        logic start;
        logic half;   // shift by one more bit: applies dt/2
    } t_mul_ctl;

    function automatic t_op next_op(input t_op op);
        t_op nxt;
        unique case (op)
            OP_DAMP:  nxt = OP_STIFF;
            OP_STIFF: nxt = OP_VEL;
            OP_VEL:   nxt = OP_POS;
            OP_POS:   nxt = OP_OUT2;
            OP_OUT2:  nxt = OP_OUT1;
            OP_OUT1:  nxt = OP_OUT0;
            OP_OUT0:  nxt = OP_DAMP;
        endcase
        return nxt;
    endfunction

endpackage

@@ design/second_order_filter_ab2.sv @@
// Top level of the second-order filter, phase-variable form, Adams-Bashforth.
// Depends on sofab_pkg and sofab_mul.
`timescale 1ns / 1ps

// Usage:
//   Input channel: i_in_valid / o_in_stall with i_sample_in, one beat per sample.
//   Output channel: o_out_valid / i_out_stall with o_sample_out, one beat per sample.
//   A beat moves at a rising edge where valid is high and stall is low.
//   Configuration: i_cfg_wen writes i_cfg_data to register i_cfg_idx
//   (0 b2, 1 b1, 2 b0, 3 a1, 4 a0, 5 dt); other indexes are ignored.
//   Write it only while no sample is in flight.
// Operation:
//   Each sample runs seven products through one digit-serial multiplier,
//   four multiplier bits per cycle, one product after another.
//   One sample is worked on at a time; o_in_stall is high from accept until
//   the result is loaded into the output register.
//   The next sample is accepted while a result still waits on a stalled output.
// Reset: synchronous, active low; states go to zero, registers to their
//   defaults, both channels empty. A stalled result holds until taken.
module second_order_filter_ab2 #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_in_valid,
    output logic                                             o_in_stall,
    input  logic signed [DATA_WIDTH-1:0]                     i_sample_in,
    output logic                                             o_out_valid,
    input  logic                                             i_out_stall,
    output logic signed [DATA_WIDTH-1:0]                     o_sample_out,
    input  logic                                             i_cfg_wen,
    input  logic [sofab_pkg::REG_IDX_W-1:0]                  i_cfg_idx,
    input  logic [((DATA_WIDTH > 31) ? DATA_WIDTH : 31)-1:0] i_cfg_data
);

    localparam int W  = DATA_WIDTH;
    localparam int MW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int SW = sofab_pkg::STEP_W;

    localparam logic signed [W+2:0] WMAX = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] WMIN = {4'b1111, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] sat_w(input logic signed [W+2:0] v);
        if (v > WMAX) begin
            return WMAX[W-1:0];
        end else if (v < WMIN) begin
            return WMIN[W-1:0];
        end
        return v[W-1:0];
    endfunction

    sofab_pkg::t_seq_state r_state, n_state;
    sofab_pkg::t_op        r_op;

    // coefficients are kept at the multiplicand width so their reset codes are exact
    logic signed [MW-1:0] r_num_s2, r_num_s1, r_num_s0, r_den_s1, r_den_s0;
    logic [SW-1:0]        r_step;

    logic signed [W-1:0]   r_u;
    logic signed [W-1:0]   r_accel, r_aprev, r_vel, r_vprev, r_pos;
    logic signed [W+1:0]   r_acc;
    logic signed [W-1:0]   r_y;
    logic                  r_out_valid;
    logic signed [W-1:0]   r_out_data;

    logic                  w_accept;
    logic                  w_load_out;
    logic                  w_mul_start;
    sofab_pkg::t_mul_ctl   w_mul_ctl;
    logic signed [MW-1:0]  w_mcand;
    logic signed [W-1:0]   w_mplier;
    logic                  w_mul_done;
    logic signed [W-1:0]   w_mul_res;
    logic signed [W-1:0]   w_now, w_prev, w_term;
    logic signed [W-1:0]   w_coef_in;

    sofab_mul #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_mul_ctl),
        .i_mcand  (w_mcand),
        .i_mplier (w_mplier),
        .o_done   (w_mul_done),
        .o_result (w_mul_res)
    );

    // ---------------- configuration ----------------
    assign w_coef_in = i_cfg_data[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_s2 <= '0;
            r_num_s1 <= '0;
            r_num_s0 <= MW'(sofab_pkg::RESET_UNITY);
            r_den_s1 <= '0;
            r_den_s0 <= MW'(sofab_pkg::RESET_UNITY);
            r_step   <= sofab_pkg::RESET_STEP;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                sofab_pkg::REG_NUM_S2: r_num_s2 <= MW'(w_coef_in);
                sofab_pkg::REG_NUM_S1: r_num_s1 <= MW'(w_coef_in);
                sofab_pkg::REG_NUM_S0: r_num_s0 <= MW'(w_coef_in);
                sofab_pkg::REG_DEN_S1: r_den_s1 <= MW'(w_coef_in);
                sofab_pkg::REG_DEN_S0: r_den_s0 <= MW'(w_coef_in);
                sofab_pkg::REG_STEP:   r_step   <= i_cfg_data[SW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- operand selection ----------------
    // bracket term of the integrator step: 3*new - previous, saturated
    always_comb begin
        if (r_op == sofab_pkg::OP_VEL) begin
            w_now  = r_accel;
            w_prev = r_aprev;
        end else begin
            w_now  = r_vel;
            w_prev = r_vprev;
        end
        w_term = sat_w((W+3)'(w_now) + ((W+3)'(w_now) <<< 1) - (W+3)'(w_prev));
    end

    always_comb begin
        w_mul_ctl.start = w_mul_start;
        w_mul_ctl.half  = 1'b0;
        w_mplier        = r_vel;
        w_mcand         = r_den_s1;
        unique case (r_op)
            sofab_pkg::OP_DAMP: begin
                w_mcand  = r_den_s1;
                w_mplier = r_vel;
            end
            sofab_pkg::OP_STIFF: begin
                w_mcand  = r_den_s0;
                w_mplier = r_pos;
            end
            sofab_pkg::OP_VEL, sofab_pkg::OP_POS: begin
                w_mcand        = {{(MW-SW){1'b0}}, r_step};
                w_mplier       = w_term;
                w_mul_ctl.half = 1'b1;
            end
            sofab_pkg::OP_OUT2: begin
                w_mcand  = r_num_s2;
                w_mplier = r_accel;
            end
            sofab_pkg::OP_OUT1: begin
                w_mcand  = r_num_s1;
                w_mplier = r_vel;
            end
            sofab_pkg::OP_OUT0: begin
                w_mcand  = r_num_s0;
                w_mplier = r_pos;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        w_accept    = 1'b0;
        w_load_out  = 1'b0;
        w_mul_start = 1'b0;
        unique case (r_state)
            sofab_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    w_accept = 1'b1;
                    n_state  = sofab_pkg::S_START;
                end
            end
            sofab_pkg::S_START: begin
                w_mul_start = 1'b1;
                n_state     = sofab_pkg::S_WAIT;
            end
            sofab_pkg::S_WAIT: begin
                if (w_mul_done) begin
                    if (r_op == sofab_pkg::OP_OUT0) begin
                        n_state = sofab_pkg::S_DONE;
                    end else begin
                        n_state = sofab_pkg::S_START;
                    end
                end
            end
            sofab_pkg::S_DONE: begin
                // hold the result until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_state    = sofab_pkg::S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sofab_pkg::S_IDLE;
            r_op    <= sofab_pkg::OP_DAMP;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_op <= sofab_pkg::OP_DAMP;
            end else if (r_state == sofab_pkg::S_WAIT && w_mul_done) begin
                r_op <= sofab_pkg::next_op(r_op);
            end
        end
    end

    // ---------------- state update ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= '0;
            r_aprev <= '0;
            r_vel   <= '0;
            r_vprev <= '0;
            r_pos   <= '0;
        end else if (r_state == sofab_pkg::S_WAIT && w_mul_done) begin
            unique case (r_op)
                sofab_pkg::OP_STIFF: begin
                    r_aprev <= r_accel;
                    r_accel <= sat_w((W+3)'(r_acc) - (W+3)'(w_mul_res));
                end
                sofab_pkg::OP_VEL: begin
                    r_vprev <= r_vel;
                    r_vel   <= sat_w((W+3)'(r_vel) + (W+3)'(w_mul_res));
                end
                sofab_pkg::OP_POS: begin
                    r_pos <= sat_w((W+3)'(r_pos) + (W+3)'(w_mul_res));
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_u <= i_sample_in;
        end
        if (r_state == sofab_pkg::S_WAIT && w_mul_done) begin
            unique case (r_op)
                sofab_pkg::OP_DAMP: r_acc <= (W+2)'(r_u) - (W+2)'(w_mul_res);
                sofab_pkg::OP_OUT2: r_acc <= (W+2)'(w_mul_res);
                sofab_pkg::OP_OUT1: r_acc <= r_acc + (W+2)'(w_mul_res);
                sofab_pkg::OP_OUT0: r_y   <= sat_w((W+3)'(r_acc) + (W+3)'(w_mul_res));
                default: ;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= r_y;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out_data;

endmodule

@@ design/sofab_mul.sv @@
// Digit-serial signed multiplier with round-half-up shift and saturation.
// Four multiplier bits per cycle, most significant digit first. Uses sofab_pkg.
`timescale 1ns / 1ps

module sofab_mul #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  sofab_pkg::t_mul_ctl                                   i_ctl,
    input  logic signed [((DATA_WIDTH > 32) ? DATA_WIDTH : 32)-1:0] i_mcand,
    input  logic signed [DATA_WIDTH-1:0]                          i_mplier,
    output logic                                                  o_done,
    output logic signed [DATA_WIDTH-1:0]                          o_result
);

    localparam int W    = DATA_WIDTH;
    localparam int MW   = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
    localparam int P    = MW + W;
    localparam int DIG  = 4;
    localparam int ND   = (W + DIG - 1) / DIG;
    localparam int SW   = ND * DIG;
    localparam int CNTW = (ND > 1) ? $clog2(ND) : 1;

    localparam logic signed [P-1:0] BIAS_LO = {{(P-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
    localparam logic signed [P-1:0] BIAS_HI = {{(P-1){1'b0}}, 1'b1} << FRAC_BITS;

    sofab_pkg::t_mul_state r_state, n_state;

    logic signed [MW-1:0]   r_mcand;
    logic [SW-1:0]          r_digits;
    logic signed [P-1:0]    r_acc;
    logic [CNTW-1:0]        r_cnt;
    logic                   r_half;
    logic                   r_done;
    logic signed [W-1:0]    r_res;

    logic [DIG-1:0]         w_top;
    logic signed [DIG:0]    w_dig;
    logic signed [MW+DIG:0] w_pp;
    logic signed [P-1:0]    w_acc_next;
    logic signed [P-1:0]    w_rnd;
    logic signed [P-1:0]    w_shr;
    logic [P-W:0]           w_hi;
    logic                   w_fits;
    logic signed [W-1:0]    w_sat;

    // Horner step: acc = acc * 16 + mcand * digit; the top digit carries the sign
    always_comb begin
        w_top = r_digits[SW-1 -: DIG];
        if (r_cnt == CNTW'(ND - 1)) begin
            w_dig = {w_top[DIG-1], w_top};
        end else begin
            w_dig = {1'b0, w_top};
        end
        w_pp       = r_mcand * w_dig;
        w_acc_next = (r_acc <<< DIG) + {{(P-MW-DIG-1){w_pp[MW+DIG]}}, w_pp};
    end

    always_comb begin
        w_rnd  = r_acc + (r_half ? BIAS_HI : BIAS_LO);
        w_shr  = r_half ? (w_rnd >>> (FRAC_BITS + 1)) : (w_rnd >>> FRAC_BITS);
        w_hi   = w_shr[P-1:W-1];
        w_fits = (&w_hi) | ~(|w_hi);
        if (w_fits) begin
            w_sat = w_shr[W-1:0];
        end else if (w_shr[P-1]) begin
            w_sat = {1'b1, {(W-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(W-1){1'b1}}};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sofab_pkg::M_IDLE: begin
                if (i_ctl.start) begin
                    n_state = sofab_pkg::M_RUN;
                end
            end
            sofab_pkg::M_RUN: begin
                if (r_cnt == '0) begin
                    n_state = sofab_pkg::M_ROUND;
                end
            end
            sofab_pkg::M_ROUND: begin
                n_state = sofab_pkg::M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sofab_pkg::M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == sofab_pkg::M_ROUND);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sofab_pkg::M_IDLE: begin
                if (i_ctl.start) begin
                    r_mcand  <= i_mcand;
                    r_digits <= SW'(i_mplier);
                    r_acc    <= '0;
                    r_cnt    <= CNTW'(ND - 1);
                    r_half   <= i_ctl.half;
                end
            end
            sofab_pkg::M_RUN: begin
                r_acc    <= w_acc_next;
                r_digits <= r_digits << DIG;
                r_cnt    <= r_cnt - 1'b1;
            end
            sofab_pkg::M_ROUND: begin
                r_res <= w_sat;
            end
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

@@ tb/sv/tb_second_order_filter_ab2.sv @@
// Testbench for second_order_filter_ab2: directed and random samples with a bit-exact
// fixed-point predictor, random sender gaps and receiver stalls.
// Depends on sofab_pkg and the second_order_filter_ab2 RTL.
`timescale 1ns / 1ps

module tb_second_order_filter_ab2;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int CFG_W  = (DATA_W > 31) ? DATA_W : 31;

    localparam longint WORD_MAX = (longint'(1) <<< (DATA_W - 1)) - 1;
    localparam longint WORD_MIN = -WORD_MAX - 1;

    // indexes past the register file: writes there must be dropped
    localparam logic [sofab_pkg::REG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [sofab_pkg::REG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;

    localparam int REPORT_LINES = 40;

    logic                              i_clk        = 1'b0;
    logic                              i_rst_n      = 1'b0;
    logic                              i_in_valid   = 1'b0;
    logic                              o_in_stall;
    logic signed [DATA_W-1:0]          i_sample_in  = '0;
    logic                              o_out_valid;
    logic                              i_out_stall  = 1'b0;
    logic signed [DATA_W-1:0]          o_sample_out;
    logic                              i_cfg_wen    = 1'b0;
    logic [sofab_pkg::REG_IDX_W-1:0]   i_cfg_idx    = '0;
    logic [CFG_W-1:0]                  i_cfg_data   = '0;

    // predictor copy of registers and states
    longint num_b2, num_b1, num_b0, den_a1, den_a0, step_dt;
    longint accel_q, vel_q, pos_q;

    logic signed [DATA_W-1:0] expected_out[$];
    int error_count = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int stall_left  = 0;

    second_order_filter_ab2 #(
        .DATA_WIDTH(DATA_W),
        .FRAC_BITS (FRAC_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample_out(o_sample_out),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #15_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic longint clamp_word(input longint v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // exact product, round half up, shift, saturate
    function automatic longint round_product(input longint a, input longint b,
                                             input int shift);
        longint p;
        p = a * b + (longint'(1) <<< (shift - 1));
        return clamp_word(p >>> shift);
    endfunction

    // two-step Adams-Bashforth; the extra shift bit applies dt/2
    function automatic longint ab2_advance(input longint acc, input longint now,
                                           input longint prev);
        longint term;
        term = clamp_word(3 * now - prev);
        return clamp_word(acc + round_product(step_dt, term, FRAC_W + 1));
    endfunction

    task automatic reset_filter_model();
        num_b2  = 0;
        num_b1  = 0;
        num_b0  = longint'(sofab_pkg::RESET_UNITY);
        den_a1  = 0;
        den_a0  = longint'(sofab_pkg::RESET_UNITY);
        step_dt = longint'(sofab_pkg::RESET_STEP);
        accel_q = 0;
        vel_q   = 0;
        pos_q   = 0;
    endtask

    task automatic apply_reg(input logic [sofab_pkg::REG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        case (idx)
            sofab_pkg::REG_NUM_S2: num_b2  = longint'($signed(data[DATA_W-1:0]));
            sofab_pkg::REG_NUM_S1: num_b1  = longint'($signed(data[DATA_W-1:0]));
            sofab_pkg::REG_NUM_S0: num_b0  = longint'($signed(data[DATA_W-1:0]));
            sofab_pkg::REG_DEN_S1: den_a1  = longint'($signed(data[DATA_W-1:0]));
            sofab_pkg::REG_DEN_S0: den_a0  = longint'($signed(data[DATA_W-1:0]));
            sofab_pkg::REG_STEP:   step_dt = longint'(data[sofab_pkg::STEP_W-1:0]);
            default: ;
        endcase
    endtask

    task automatic predict_sample(input logic signed [DATA_W-1:0] u);
        longint accel_prev, vel_prev, y;
        accel_prev = accel_q;
        vel_prev   = vel_q;
        accel_q = clamp_word(longint'(u) - round_product(den_a1, vel_q, FRAC_W)
                                         - round_product(den_a0, pos_q, FRAC_W));
        vel_q = ab2_advance(vel_q, accel_q, accel_prev);
        pos_q = ab2_advance(pos_q, vel_q, vel_prev);
        y = round_product(num_b2, accel_q, FRAC_W)
          + round_product(num_b1, vel_q, FRAC_W)
          + round_product(num_b0, pos_q, FRAC_W);
        expected_out.push_back(DATA_W'(clamp_word(y)));
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string msg);
        if (error_count < REPORT_LINES)
            $display("%0t ns: %s", $time, msg);
        error_count++;
    endtask

    always @(posedge i_clk) begin : check_output
        logic signed [DATA_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_out.size() == 0) begin
                report_mismatch($sformatf("unexpected output beat %h", o_sample_out));
            end else begin
                want = expected_out.pop_front();
                if (o_sample_out !== want)
                    report_mismatch($sformatf("sample_out got %h, want %h",
                                              o_sample_out, want));
            end
        end
    end

    // receiver: short stalls mostly, now and then a long one
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            i_out_stall <= 1'b1;
            stall_left  <= ($urandom_range(0, 15) == 0) ? $urandom_range(20, 120)
                                                        : $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- drivers

    // leave valid high after the beat; the next call lowers it only for a gap, a drain lowers it
    task automatic send_sample(input logic signed [DATA_W-1:0] u);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 100)
                                              : $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= u;
        do @(posedge i_clk); while (o_in_stall);
        predict_sample(u);
    endtask

    task automatic hold_until_idle();
        i_in_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sofab_pkg::REG_IDX_W-1:0] idx,
                             input logic [CFG_W-1:0] data);
        i_cfg_wen  <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_wen  <= 1'b0;
        apply_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] b2, input logic [CFG_W-1:0] b1,
                              input logic [CFG_W-1:0] b0, input logic [CFG_W-1:0] a1,
                              input logic [CFG_W-1:0] a0, input logic [CFG_W-1:0] dt);
        hold_until_idle();
        write_reg(sofab_pkg::REG_NUM_S2, b2);
        write_reg(sofab_pkg::REG_NUM_S1, b1);
        write_reg(sofab_pkg::REG_NUM_S0, b0);
        write_reg(sofab_pkg::REG_DEN_S1, a1);
        write_reg(sofab_pkg::REG_DEN_S0, a0);
        write_reg(sofab_pkg::REG_STEP,   dt);
    endtask

    // tame: stable poles, small step; wild: any code in every register
    task automatic pick_config(input bit wild);
        if (wild)
            set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        else
            set_config(int'($urandom_range(0, 8 * 65536)) - 4 * 65536,
                       int'($urandom_range(0, 8 * 65536)) - 4 * 65536,
                       int'($urandom_range(0, 8 * 65536)) - 4 * 65536,
                       $urandom_range(0, 2 * 65536),
                       $urandom_range(0, 4 * 65536),
                       $urandom_range(1, 3277));
    endtask

    // ---------------------------------------------------------------- tests

    // states start at zero with the register defaults
    task automatic test_reset_state();
        send_sample(Q_ONE);
        send_sample(Q_ONE);
        send_sample(Q_MAX);
        send_sample(Q_MIN);
    endtask

    task automatic test_extreme_registers();
        set_config(Q_MAX, Q_MIN, 32'hFFFF_FFFF, Q_MIN, Q_MAX, 32'h7FFF_FFFF);
        send_sample(Q_MAX);
        send_sample(Q_MIN);
        send_sample('0);
        send_sample(32'sd1);
        send_sample(-32'sd1);
        send_sample(Q_MAX);
        set_config(Q_MIN, Q_MAX, '0, Q_MAX, Q_MIN, 32'd1);
        send_sample(Q_MIN);
        send_sample(Q_MAX);
        send_sample(Q_MIN);
    endtask

    // velocity and position hold; only the acceleration path moves
    task automatic test_zero_step();
        set_config(Q_ONE, Q_ONE, Q_ONE, 32'sd32768, Q_ONE, '0);
        send_sample(32'sd131072);
        send_sample(-32'sd196608);
        send_sample(32'sd327680);
    endtask

    // out-of-range indexes drop the write; bit 31 of the step is not stored
    task automatic test_ignored_writes();
        hold_until_idle();
        write_reg(REG_UNUSED_LO, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED_HI, 32'h8000_0001);
        write_reg(sofab_pkg::REG_STEP, 32'h8000_0291);
        send_sample(Q_ONE);
        send_sample(-32'sd65536);
        send_sample(32'sd655360);
    endtask

    task automatic test_random_phases();
        int phase, n;
        logic signed [DATA_W-1:0] level;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 68; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 68; end
                default: begin idle_pct = 28; stall_pct = 28; end
            endcase
            level = '0;
            for (n = 0; n < 200; n++) begin
                if (n % 100 == 0)
                    pick_config(phase == 4);
                // step-like input: hold a level for a while, with small noise and now and then a random word
                if ($urandom_range(0, 7) == 0)
                    level = ($urandom_range(0, 3) == 0) ? $urandom
                                                        : int'($urandom_range(0, 1 << 24))
                                                          - (1 << 23);
                if ($urandom_range(0, 5) == 0)
                    send_sample($urandom);
                else
                    send_sample(level + int'($urandom_range(0, 255)) - 128);
            end
        end
    endtask

    initial begin
        reset_filter_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_extreme_registers();
        test_zero_step();
        test_ignored_writes();
        test_random_phases();

        hold_until_idle();
        repeat (100) @(posedge i_clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ second_order_filter_ab2.f @@
design/sofab_pkg.sv
design/sofab_mul.sv
design/second_order_filter_ab2.sv
tb/sv/tb_second_order_filter_ab2.sv
